@@ rtl/rc4_pkg.sv @@
// shared types and constants for the rc4 stream cipher
`default_nettype none

package rc4_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SBOX_DEPTH = 256;
    localparam int unsigned CNT_W      = 9;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] byte_in;
        logic              key_last;
    } rc4_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              key_missing;
    } rc4_out_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_KEY,
        OP_KEY_LAST,
        OP_CAPTURE,
        OP_FILL,
        OP_KSA_RD,
        OP_KSA_J,
        OP_KSA_W1,
        OP_KSA_W2,
        OP_KS_J,
        OP_KS_T,
        OP_KS_OUT,
        OP_PASS
    } rc4_op_t;

    typedef struct packed {
        rc4_op_t op;
        logic    out_load;
    } rc4_cmd_t;

    typedef struct packed {
        logic n_last;
    } rc4_status_t;

endpackage

`default_nettype wire

@@ rtl/rc4_dp.sv @@
// rc4 datapath: permutation and key memories, indices and output register
`default_nettype none

module rc4_dp
    import rc4_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire rc4_in_t     in_data,
    input  wire rc4_cmd_t    cmd,
    output rc4_status_t      status,
    output rc4_out_t         out_data
);

    localparam int unsigned KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEY_BYTES);

    logic [BYTE_W-1:0] s_mem [SBOX_DEPTH];
    logic [BYTE_W-1:0] k_mem [MAX_KEY_BYTES];

    logic [BYTE_W-1:0] s_rdata_reg;
    logic [BYTE_W-1:0] k_rdata_reg;

    logic [CNT_W-1:0]  key_count_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [BYTE_W-1:0] i_reg;
    logic [BYTE_W-1:0] j_reg;
    logic [BYTE_W-1:0] n_reg;
    logic [BYTE_W-1:0] jj_reg;
    logic [KW-1:0]     kidx_reg;
    logic [BYTE_W-1:0] si_reg;
    logic [BYTE_W-1:0] sj_reg;
    logic [BYTE_W-1:0] t_reg;
    logic              hit_i_reg;
    logic              hit_j_reg;
    logic [BYTE_W-1:0] data_reg;
    rc4_out_t          out_data_reg;

    logic [BYTE_W-1:0] jj_sum;
    logic [BYTE_W-1:0] j_sum;
    logic [BYTE_W-1:0] t_sum;
    logic [BYTE_W-1:0] i_inc;
    logic [BYTE_W-1:0] keystream;
    logic [BYTE_W-1:0] s_raddr;
    logic [BYTE_W-1:0] s_waddr;
    logic [BYTE_W-1:0] s_wdata;
    logic              s_we;
    logic              key_room;
    logic              k_we;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  kidx_inc;

    assign jj_sum    = jj_reg + k_rdata_reg + s_rdata_reg;
    assign j_sum     = j_reg + s_rdata_reg;
    assign t_sum     = si_reg + s_rdata_reg;
    assign i_inc     = i_reg + 8'd1;
    assign key_room  = key_count_reg < MAX_CNT;
    assign k_we      = key_room && (cmd.op == OP_KEY || cmd.op == OP_KEY_LAST);
    assign count_inc = key_room ? key_count_reg + 9'd1 : key_count_reg;
    assign kidx_inc  = {{(CNT_W-KW){1'b0}}, kidx_reg} + 9'd1;
    assign keystream = hit_j_reg ? si_reg : (hit_i_reg ? sj_reg : s_rdata_reg);

    assign status.n_last = (n_reg == 8'hFF);
    assign out_data      = out_data_reg;

    // permutation read address
    always_comb
    begin
        unique case (cmd.op)
            OP_KSA_RD: s_raddr = n_reg;
            OP_KSA_J:  s_raddr = jj_sum;
            OP_KS_J:   s_raddr = j_sum;
            OP_KS_T:   s_raddr = t_sum;
            OP_KS_OUT: s_raddr = t_reg;
            default:   s_raddr = i_inc;
        endcase
    end

    // permutation write port, the swap takes two writes
    always_comb
    begin
        s_we    = 1'b1;
        s_waddr = n_reg;
        s_wdata = n_reg;
        unique case (cmd.op)
            OP_FILL:
            begin
                s_waddr = n_reg;
                s_wdata = n_reg;
            end
            OP_KSA_W1:
            begin
                s_waddr = n_reg;
                s_wdata = s_rdata_reg;
            end
            OP_KSA_W2:
            begin
                s_waddr = jj_reg;
                s_wdata = si_reg;
            end
            OP_KS_T:
            begin
                s_waddr = i_reg;
                s_wdata = s_rdata_reg;
            end
            OP_KS_OUT:
            begin
                s_waddr = j_reg;
                s_wdata = si_reg;
            end
            default:
            begin
                s_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            s_mem[s_waddr] <= s_wdata;
        end
        s_rdata_reg <= s_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            k_mem[key_count_reg[KW-1:0]] <= in_data.byte_in;
        end
        k_rdata_reg <= k_mem[kidx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_KEY:
                begin
                    key_count_reg <= count_inc;
                end
                OP_KEY_LAST:
                begin
                    key_count_reg <= '0;
                end
                OP_KSA_W2:
                begin
                    if (status.n_last)
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                    end
                end
                OP_KS_J:
                begin
                    i_reg <= i_inc;
                    j_reg <= j_sum;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_KEY_LAST:
            begin
                len_reg  <= count_inc;
                n_reg    <= '0;
                jj_reg   <= '0;
                kidx_reg <= '0;
            end
            OP_CAPTURE:
            begin
                data_reg <= in_data.byte_in;
            end
            OP_FILL:
            begin
                n_reg <= n_reg + 8'd1;
            end
            OP_KSA_J:
            begin
                si_reg <= s_rdata_reg;
                jj_reg <= jj_sum;
            end
            OP_KSA_W2:
            begin
                n_reg <= n_reg + 8'd1;
                if (kidx_inc == len_reg)
                begin
                    kidx_reg <= '0;
                end
                else
                begin
                    kidx_reg <= kidx_inc[KW-1:0];
                end
            end
            OP_KS_J:
            begin
                si_reg <= s_rdata_reg;
            end
            OP_KS_T:
            begin
                sj_reg    <= s_rdata_reg;
                t_reg     <= t_sum;
                hit_i_reg <= (t_sum == i_reg);
                hit_j_reg <= (t_sum == j_reg);
            end
            default:
            begin
            end
        endcase

        if (cmd.out_load)
        begin
            if (cmd.op == OP_PASS)
            begin
                out_data_reg.byte_out    <= data_reg;
                out_data_reg.key_missing <= 1'b1;
            end
            else
            begin
                out_data_reg.byte_out    <= data_reg ^ keystream;
                out_data_reg.key_missing <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/rc4_ctrl.sv @@
// rc4 controller: sequences key schedule, keystream steps and output transfer
`default_nettype none

module rc4_ctrl
    import rc4_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire rc4_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output rc4_cmd_t         cmd,
    input  wire rc4_status_t status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_KSA_RD,
        S_KSA_J,
        S_KSA_W1,
        S_KSA_W2,
        S_KS_J,
        S_KS_T,
        S_KS_OUT,
        S_PASS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   keyed_reg;
    logic   keyed_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        keyed_next   = keyed_reg;
        cmd.op       = OP_IDLE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.command == CMD_KEY)
                    begin
                        if (in_data.key_last)
                        begin
                            cmd.op     = OP_KEY_LAST;
                            state_next = S_FILL;
                        end
                        else
                        begin
                            cmd.op = OP_KEY;
                        end
                    end
                    else
                    begin
                        cmd.op     = OP_CAPTURE;
                        state_next = keyed_reg ? S_KS_J : S_PASS;
                    end
                end
            end
            S_FILL:
            begin
                cmd.op = OP_FILL;
                if (status.n_last)
                begin
                    state_next = S_KSA_RD;
                end
            end
            S_KSA_RD:
            begin
                cmd.op     = OP_KSA_RD;
                state_next = S_KSA_J;
            end
            S_KSA_J:
            begin
                cmd.op     = OP_KSA_J;
                state_next = S_KSA_W1;
            end
            S_KSA_W1:
            begin
                cmd.op     = OP_KSA_W1;
                state_next = S_KSA_W2;
            end
            S_KSA_W2:
            begin
                cmd.op = OP_KSA_W2;
                if (status.n_last)
                begin
                    keyed_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_KSA_RD;
                end
            end
            S_KS_J:
            begin
                cmd.op     = OP_KS_J;
                state_next = S_KS_T;
            end
            S_KS_T:
            begin
                cmd.op     = OP_KS_T;
                state_next = S_KS_OUT;
            end
            S_KS_OUT:
            begin
                cmd.op = OP_KS_OUT;
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_PASS:
            begin
                cmd.op = OP_PASS;
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rc4_stream_cipher.sv @@
// rc4 stream cipher top level
// keyed data byte: capture, KS_J, KS_T and KS_OUT run the read, read, read-and-swap,
//   write sequence on the s_mem read and write ports; in_stall stays up until loaded
// data byte before any key: passed with key_missing set; both wait for a free output slot
// key byte: stored; final key byte: 256-entry fill, then per entry KSA_RD/J/W1/W2 steps
// reset clears i and j, key count and keyed flag; memories hold no reset value
`default_nettype none

module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = 256
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire rc4_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output rc4_out_t      out_data
);

    rc4_cmd_t    cmd;
    rc4_status_t status;

    rc4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    rc4_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
